>>> rtl/core/sacl_pkg.sv
`timescale 1ns / 1ps

package sacl_pkg;

	// built geometry
	localparam int WAYS_DEF = 8;
	localparam int SETS_DEF = 256;

	// address and field widths
	localparam int ADDR_W = 24;
	localparam int CFG_W  = 4;
	localparam int CIDX_W = 2;
	// widest set number before the modulo: index_bits reaches 15
	localparam int XW     = 15;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_OFFSET_BITS = 2'd0;
	localparam logic [CIDX_W-1:0] REG_INDEX_BITS  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_WAYS_USED   = 2'd2;

	// reset values of the registers
	localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd4;
	localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd8;
	localparam logic [CFG_W-1:0] WAYS_USED_RST   = 4'd8;

	// access kinds
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_STORE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_QUOT,
		ST_READ,
		ST_LOOK
	} state_t;

endpackage

>>> rtl/core/set_assoc_cache_lru_lookup.sv
`timescale 1ns / 1ps

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: address[23:0]; tuser: mode
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: hit, filled, zero pad
// cfg       in   cfg_valid / cfg_ready          cfg_index[1:0], cfg_data[3:0]
//
// an item passes through accept, a quotient step when SETS is not a power of two
// (reciprocal multiply for the set modulo), registered read of the set row and lookup with
// row write-back, its result registered; the next accept follows the end of the lookup
// after reset a clearing pass writes every set row once, with s_axis_tready low
// a result waiting on m_axis does not block the next accept; that item holds in the lookup
// stage, its memory write deferred until the output register frees
// cfg_ready is always high, also during the clearing pass

module set_assoc_cache_lru_lookup
	import sacl_pkg::*;
#(
	parameter int WAYS = WAYS_DEF,
	parameter int SETS = SETS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// access items
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [ADDR_W-1:0] s_axis_tdata,   // address[23:0]
	input  logic              s_axis_tuser,   // mode (0 load, 1 store)
	// lookup results
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,   // hit, filled, 6 bits zero
	// configuration writes
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	// geometry derived from the parameters
	localparam int AW      = (WAYS > 1) ? $clog2(WAYS) : 1;     // age and way number width
	localparam int NW      = $clog2(WAYS + 1);                  // ways in use count width
	localparam int IDXW    = (SETS > 1) ? $clog2(SETS) : 1;     // set address width
	localparam bit SETS_P2 = ((SETS & (SETS - 1)) == 0);
	// reciprocal for the set modulo, exact for every value below 2^XW
	localparam int SH      = XW + IDXW;
	localparam int RECIP   = ((1 << SH) + SETS - 1) / SETS;
	localparam logic [AW-1:0] AGE_MAX = AW'(WAYS - 1);

	// one memory row holds a whole set
	typedef struct packed {
		logic [WAYS-1:0][ADDR_W-1:0] tag;
		logic [WAYS-1:0][AW-1:0]     age;
		logic [WAYS-1:0]             valid;
	} row_t;

	// configuration registers
	logic [CFG_W-1:0] offset_bits_q;
	logic [CFG_W-1:0] index_bits_q;
	logic [CFG_W-1:0] ways_used_q;

	state_t state_q, state_d;
	logic [IDXW-1:0] clr_q;

	// pipeline of one item
	logic              mode_s1;
	logic [ADDR_W-1:0] tag_s1;
	logic [XW-1:0]     x_s1;      // set number before the modulo
	logic [XW-1:0]     q_s2;      // quotient by SETS
	logic [IDXW-1:0]   set_s3;
	row_t              rd_s3;

	logic       m_valid_q;
	logic [1:0] m_data_q;

	row_t mem [SETS];

	// control decoded from the state
	logic in_acc, rd_en, clr_en, look, adv, last_clr;
	logic wr_en;
	logic [IDXW-1:0] wr_addr;
	row_t wr_row;

	// address split on the incoming item
	logic [ADDR_W-1:0] addr_sh;
	logic [XW-1:0]     x_mask;
	logic [4:0]        tag_sh;

	// set number after the modulo
	logic [31:0]     quot_prod;
	logic [XW-1:0]   qs;
	logic [XW-1:0]   rem;
	logic [IDXW-1:0] set_rd;

	// lookup of the read row
	logic [NW-1:0]   n_eff;
	logic [WAYS-1:0] en, match, inv;
	logic            hit, found, upd, fill;
	logic [AW-1:0]   hw, iw, vw, w;
	logic [AW-1:0]   oldest;
	logic [AW:0]     prior;
	row_t            new_row;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= OFFSET_BITS_RST;
			index_bits_q  <= INDEX_BITS_RST;
			ways_used_q   <= WAYS_USED_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OFFSET_BITS: offset_bits_q <= cfg_data;
				REG_INDEX_BITS:  index_bits_q  <= cfg_data;
				REG_WAYS_USED:   ways_used_q   <= cfg_data;
				default: ;  // unknown index is dropped
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (last_clr) state_d = ST_IDLE;
			ST_IDLE:  if (s_axis_tvalid) state_d = SETS_P2 ? ST_READ : ST_QUOT;
			ST_QUOT:  state_d = ST_READ;
			ST_READ:  state_d = ST_LOOK;
			ST_LOOK:  if (adv) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		clr_en        = 1'b0;
		look          = 1'b0;
		case (state_q)
			ST_CLEAR: clr_en        = 1'b1;
			ST_IDLE:  s_axis_tready = 1'b1;
			ST_READ:  rd_en         = 1'b1;
			ST_LOOK:  look          = 1'b1;
			default: ;
		endcase
	end

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign last_clr = (clr_q == IDXW'(SETS - 1));
	// the output register is free or hands its result over this cycle
	assign adv      = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clr_en) clr_q <= clr_q + 1'b1;
		end
	end

	// offset, index and tag of the incoming address
	always_comb begin
		addr_sh = s_axis_tdata >> offset_bits_q;
		x_mask  = XW'((16'd1 << index_bits_q) - 16'd1);
		tag_sh  = {1'b0, offset_bits_q} + {1'b0, index_bits_q};
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_s1 <= s_axis_tuser;
			x_s1    <= addr_sh[XW-1:0] & x_mask;
			tag_s1  <= s_axis_tdata >> tag_sh;   // zero once the split reaches 24 bits
		end
	end

	// set modulo: quotient by reciprocal, then remainder
	assign quot_prod = 32'(x_s1) * 32'(RECIP);

	always_ff @(posedge clk) begin
		if (state_q == ST_QUOT) q_s2 <= XW'(quot_prod >> SH);
	end

	always_comb begin
		qs  = XW'(32'(q_s2) * 32'(SETS));
		rem = x_s1 - qs;
		if (SETS == 1) set_rd = '0;
		else if (SETS_P2) set_rd = x_s1[IDXW-1:0];
		else set_rd = rem[IDXW-1:0];
	end

	// set memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_row;
		if (rd_en) begin
			rd_s3  <= mem[set_rd];
			set_s3 <= set_rd;
		end
	end

	// hit search, free way, lru victim and age update
	always_comb begin
		if (ways_used_q == '0) n_eff = NW'(1);
		else if (int'(ways_used_q) > WAYS) n_eff = NW'(WAYS);
		else n_eff = NW'(ways_used_q);

		for (int j = 0; j < WAYS; j++) begin
			en[j]    = (NW'(j) < n_eff);
			match[j] = en[j] && rd_s3.valid[j] && (rd_s3.tag[j] == tag_s1);
			inv[j]   = en[j] && !rd_s3.valid[j];
		end

		// lowest matching way and lowest free way
		hit   = |match;
		found = |inv;
		hw    = '0;
		iw    = '0;
		for (int j = WAYS - 1; j >= 0; j--) begin
			if (match[j]) hw = AW'(j);
			if (inv[j])   iw = AW'(j);
		end

		// oldest way, the lowest one on a tie
		vw     = '0;
		oldest = rd_s3.age[0];
		for (int j = 1; j < WAYS; j++) begin
			if (en[j] && rd_s3.age[j] > oldest) begin
				oldest = rd_s3.age[j];
				vw     = AW'(j);
			end
		end

		fill = !hit && (mode_s1 == MODE_LOAD);
		upd  = hit || fill;

		if (hit) begin
			w     = hw;
			prior = {1'b0, rd_s3.age[hw]};
		end else if (found) begin
			// a fresh way counts as older than all
			w     = iw;
			prior = (AW + 1)'(WAYS);
		end else begin
			w     = vw;
			prior = {1'b0, oldest};
		end

		new_row = rd_s3;
		for (int j = 0; j < WAYS; j++) begin
			if (AW'(j) == w) begin
				new_row.age[j] = '0;
				if (fill) begin
					new_row.tag[j]   = tag_s1;
					new_row.valid[j] = 1'b1;
				end
			end else if (en[j] && rd_s3.valid[j] && ({1'b0, rd_s3.age[j]} < prior)
					&& (rd_s3.age[j] < AGE_MAX)) begin
				new_row.age[j] = rd_s3.age[j] + 1'b1;
			end
		end
	end

	// write port: clearing pass or write-back of the looked-up set
	always_comb begin
		wr_en   = clr_en || (look && adv && upd);
		wr_addr = clr_en ? clr_q : set_s3;
		wr_row  = clr_en ? '0 : new_row;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (look && adv) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (look && adv) m_data_q <= {fill, hit};
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, m_data_q};

	// one item at a time: an accept is never followed by another in the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("item accepted while another is in work");

	// a finished lookup always shows up as a result
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(look && adv) |=> m_axis_tvalid)
		else $error("lookup finished without a result");

	// a blocked lookup keeps its place and does not write back
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(look && !adv) |-> (!wr_en ##1 state_q == ST_LOOK))
		else $error("lookup left or wrote while the output was full");

	// a hit never allocates
	a_hit_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(m_data_q[0] && m_data_q[1]))
		else $error("hit and filled both set");

endmodule

>>> tb/tb_set_assoc_cache_lru_lookup.sv
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_lookup;
	import sacl_pkg::*;

	// built geometry of the block under test
	localparam int WAYS    = WAYS_DEF;
	localparam int SETS    = SETS_DEF;
	localparam int ENTRIES = WAYS * SETS;
	localparam int AGE_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int AGE_MAX = WAYS - 1;

	// register index that the block has no register for
	localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

	// generous cycle limit: clearing pass plus a few hundred slow items many times over
	localparam int CYCLE_LIMIT = 400000;
	// receiver hold-off used to back the block up
	localparam int HOLD_CYCLES = 300;

	// expected outcome of one lookup
	typedef struct packed {
		logic hit;
		logic filled;
	} lookup_t;

	// tag, valid and age store of the directory, plus the split it is read with
	class cache_directory;
		logic [ADDR_W-1:0] tag_mem [ENTRIES];
		logic              valid_mem [ENTRIES];
		logic [AGE_W-1:0]  age_mem [ENTRIES];
		logic [CFG_W-1:0]  offset_bits;
		logic [CFG_W-1:0]  index_bits;
		logic [CFG_W-1:0]  ways_used;
		lookup_t           lookup_q [$];
		int                errors;

		function new();
			int e;
			for (e = 0; e < ENTRIES; e++) begin
				tag_mem[e]   = '0;
				valid_mem[e] = 1'b0;
				age_mem[e]   = '0;
			end
			offset_bits = OFFSET_BITS_RST;
			index_bits  = INDEX_BITS_RST;
			ways_used   = WAYS_USED_RST;
			errors      = 0;
		endfunction

		function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_OFFSET_BITS: offset_bits = data;
				REG_INDEX_BITS:  index_bits  = data;
				REG_WAYS_USED:   ways_used   = data;
				default: ;
			endcase
		endfunction

		// way w becomes most recent; valid ways younger than its prior age grow older
		function void touch_way(int base, int n, int w, int prior);
			int j;
			for (j = 0; j < n; j++) begin
				if (j != w && valid_mem[base + j] && age_mem[base + j] < prior
						&& age_mem[base + j] < AGE_MAX)
					age_mem[base + j] = age_mem[base + j] + 1'b1;
			end
			age_mem[base + w] = '0;
		endfunction

		function void record_access(logic mode, logic [ADDR_W-1:0] addr);
			int unsigned a, ob, ib, set, tag;
			int          n, base, j, w, oldest;
			logic        found;
			lookup_t     res;
			a   = addr;
			ob  = offset_bits;
			ib  = index_bits;
			set = ((a >> ob) & ((32'd1 << ib) - 1)) % SETS;
			tag = a >> (ob + ib);
			n   = ways_used;
			if (n < 1)
				n = 1;
			if (n > WAYS)
				n = WAYS;
			base  = set * WAYS;
			res   = '0;
			found = 1'b0;
			w     = 0;
			// lowest matching valid way wins
			for (j = 0; j < n; j++) begin
				if (valid_mem[base + j] && tag_mem[base + j] == tag[ADDR_W-1:0]) begin
					touch_way(base, n, j, age_mem[base + j]);
					res.hit = 1'b1;
					break;
				end
			end
			// load miss allocates, store miss leaves the set alone
			if (!res.hit && mode == MODE_LOAD) begin
				for (j = 0; j < n; j++) begin
					if (!valid_mem[base + j]) begin
						w     = j;
						found = 1'b1;
						break;
					end
				end
				if (found) begin
					touch_way(base, n, w, WAYS);
				end else begin
					oldest = age_mem[base];
					for (j = 1; j < n; j++) begin
						if (age_mem[base + j] > oldest) begin
							oldest = age_mem[base + j];
							w      = j;
						end
					end
					touch_way(base, n, w, oldest);
				end
				tag_mem[base + w]   = tag[ADDR_W-1:0];
				valid_mem[base + w] = 1'b1;
				res.filled          = 1'b1;
			end
			lookup_q.push_back(res);
		endfunction

		function void check_lookup(logic [7:0] data);
			lookup_t exp;
			if (lookup_q.size() == 0) begin
				$error("lookup result with no access pending: tdata %02h", data);
				errors++;
				return;
			end
			exp = lookup_q.pop_front();
			if (data[0] !== exp.hit) begin
				$error("hit: expected %0d, actual %0d", exp.hit, data[0]);
				errors++;
			end
			if (data[1] !== exp.filled) begin
				$error("filled: expected %0d, actual %0d", exp.filled, data[1]);
				errors++;
			end
		endfunction

		function int pending();
			return lookup_q.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [ADDR_W-1:0] s_axis_tdata;   // address[23:0]
	logic              s_axis_tuser;   // mode
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [7:0]        m_axis_tdata;   // hit, filled, zero pad
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	cache_directory dir_model;

	// current split, used to aim random addresses at a few busy sets
	logic [CFG_W-1:0] cur_ob;
	logic [CFG_W-1:0] cur_ib;
	logic [CFG_W-1:0] cur_wu;

	// idle odds in percent per cycle, per side
	int  send_idle_pct;
	int  recv_stall_pct;
	// bumped by the stimulus for each long hold-off, followed by the receiver
	int  hold_reqs;
	int  cycle_count;

	set_assoc_cache_lru_lookup #(
		.WAYS(WAYS),
		.SETS(SETS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// handshake monitor: values seen here are the ones from before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				dir_model.check_lookup(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				dir_model.record_access(s_axis_tuser, s_axis_tdata);
			if (cfg_valid && cfg_ready)
				dir_model.write_reg(cfg_index, cfg_data);
		end
	end

	// receiver: random stalls, or a long counted hold-off on request
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// offer one access, with a random gap first; valid stays high after accept
	task automatic send_access(input logic mode, input logic [ADDR_W-1:0] addr);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= addr;
		s_axis_tuser  <= mode;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop offering and wait for every outstanding lookup result
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (dir_model.pending() != 0);
	endtask

	task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// new split, only with the block idle; the unused index is poked too
	task automatic reconfigure(input logic [CFG_W-1:0] ob, input logic [CFG_W-1:0] ib,
			input logic [CFG_W-1:0] wu);
		drain();
		cfg_write(REG_UNUSED, CFG_W'($urandom));
		cfg_write(REG_OFFSET_BITS, ob);
		cfg_write(REG_INDEX_BITS, ib);
		cfg_write(REG_WAYS_USED, wu);
		cfg_valid <= 1'b0;
		cur_ob = ob;
		cur_ib = ib;
		cur_wu = wu;
	endtask

	// address of a block under the reset split
	function automatic logic [ADDR_W-1:0] block_addr(input int unsigned tag,
			input int unsigned set);
		return ADDR_W'((tag << 12) | (set << 4));
	endfunction

	// mostly a few sets and a few more tags than ways, so hits and evictions are common;
	// sets beyond SETS alias back through the modulo
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned ob, ib, n, off, set, tag, a;
		ob = cur_ob;
		ib = cur_ib;
		n  = cur_wu;
		if (n < 1)
			n = 1;
		if (n > WAYS)
			n = WAYS;
		if ($urandom_range(0, 3) == 0)
			return ADDR_W'($urandom);
		off = $urandom & ((32'd1 << ob) - 1);
		set = $urandom_range(0, 3) + ($urandom_range(0, 1) ? SETS : 0);
		tag = $urandom_range(0, n + 2);
		a   = (tag << (ob + ib)) | ((set & ((32'd1 << ib) - 1)) << ob) | off;
		return a[ADDR_W-1:0];
	endfunction

	task automatic run_phase(input logic [CFG_W-1:0] ob, input logic [CFG_W-1:0] ib,
			input logic [CFG_W-1:0] wu, input int send_pct, input int recv_pct,
			input int count, input logic backpressure);
		int  k;
		logic mode;
		reconfigure(ob, ib, wu);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		// long receiver hold-off while items keep coming, so the input stalls
		if (backpressure)
			hold_reqs++;
		for (k = 0; k < count; k++) begin
			mode = ($urandom_range(0, 99) < 30) ? MODE_STORE : MODE_LOAD;
			send_access(mode, pick_address());
		end
	endtask

	initial begin
		int t;
		dir_model      = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_reqs      = 0;
		cur_ob         = OFFSET_BITS_RST;
		cur_ib         = INDEX_BITS_RST;
		cur_wu         = WAYS_USED_RST;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= MODE_LOAD;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_OFFSET_BITS;
		cfg_data      <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under the reset split, no idling
		reconfigure(OFFSET_BITS_RST, INDEX_BITS_RST, WAYS_USED_RST);
		send_access(MODE_LOAD, 24'h000000);    // cold miss fills
		send_access(MODE_LOAD, 24'h00000F);    // same block, hit
		send_access(MODE_STORE, 24'hFFFFFF);   // store miss, no allocate
		send_access(MODE_LOAD, 24'hFFFFFF);    // fill of the top set
		send_access(MODE_STORE, 24'hFFFFF0);   // store hit
		// fill every way of set 0, then force evictions of the oldest
		for (t = 1; t < WAYS; t++)
			send_access(MODE_LOAD, block_addr(t, 0));
		send_access(MODE_LOAD, block_addr(2, 0));   // hit moves way to front
		send_access(MODE_LOAD, block_addr(8, 0));   // evicts tag 0
		send_access(MODE_LOAD, block_addr(0, 0));   // evicts tag 1

		// duplicate tags across ways after shrinking and regrowing the way count
		reconfigure(OFFSET_BITS_RST, INDEX_BITS_RST, 4'd2);
		send_access(MODE_LOAD, block_addr(9, 1));
		send_access(MODE_LOAD, block_addr(10, 1));
		reconfigure(OFFSET_BITS_RST, INDEX_BITS_RST, 4'd1);
		send_access(MODE_LOAD, block_addr(11, 1));  // replaces way 0
		send_access(MODE_LOAD, block_addr(10, 1));  // way 1 unseen, way 0 takes tag 10
		reconfigure(OFFSET_BITS_RST, INDEX_BITS_RST, 4'd2);
		send_access(MODE_LOAD, block_addr(10, 1));  // both ways match, lowest hits
		send_access(MODE_STORE, block_addr(9, 1));

		// random part over several splits and idle patterns
		run_phase(4'd4,  4'd8,  4'd8,  0,  0,  80, 1'b0);
		run_phase(4'd0,  4'd0,  4'd1,  79, 0,  60, 1'b0);  // one set, one way
		run_phase(4'd10, 4'd8,  4'd8,  0,  79, 70, 1'b0);  // largest legal blocks
		run_phase(4'd2,  4'd3,  4'd4,  16, 16, 70, 1'b0);
		run_phase(4'd15, 4'd15, 4'd15, 0,  0,  50, 1'b0);  // split past the tag, ways clamp
		run_phase(4'd3,  4'd9,  4'd0,  0,  79, 60, 1'b0);  // index wraps, zero ways acts as one
		run_phase(4'd1,  4'd2,  4'd3,  16, 16, 60, 1'b1);  // with receiver hold-off
		run_phase(4'd6,  4'd5,  4'd8,  0,  0,  50, 1'b0);

		// all results in, then a few cycles for anything unexpected
		drain();
		repeat (8) @(posedge clk);
		if (dir_model.errors == 0 && dir_model.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/sacl_pkg.sv
rtl/core/set_assoc_cache_lru_lookup.sv
tb/tb_set_assoc_cache_lru_lookup.sv
